// ===== rtl/oait_pkg.sv =====
// Shared types and constants for the open-addressed inode table.
// Depends on nothing; every file of the block imports it.
`timescale 1ns / 1ps

package oait_pkg;

   // Table geometry. The slot count must be a power of two, so the home slot
   // is the low bits of the key.
   localparam int TABLE_SIZE = 1024;
   localparam int IDX_W      = $clog2(TABLE_SIZE);

   // Field widths fixed by the interface.
   localparam int KEY_W   = 16;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;
   localparam int SLOT_W  = 10;
   localparam int LIMIT_W = 10;
   localparam int CNT_W   = 11;
   localparam int ENTRY_W = 2 * KEY_W;

   localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RESET = LIMIT_W'(1013);

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SET    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_HIT      = 2'd0;
   localparam logic [STAT_W-1:0] ST_INSERTED = 2'd1;
   localparam logic [STAT_W-1:0] ST_MISS     = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_PROBE,
      S_CLEAR
   } state_type;

endpackage

// ===== rtl/open_addressed_inode_table.sv =====
// Top level of the open-addressed inode table: sequencer, slot memory and
// result registers. Depends on oait_pkg.
`timescale 1ns / 1ps

// Usage
// A request word (req_mode, req_key_inode, req_parent_inode) is taken at a
// rising edge where start is high and busy is low. Each request gives one
// result word on the rsp_ ports for exactly one cycle, marked by rsp_valid;
// the receiver cannot hold it off. A key of zero (not in clear mode) answers
// miss in the cycle after it is taken. A probing request reads one slot per
// cycle through the single slot memory port and visits at most TABLE_SIZE
// slots before its result is shown. Clear writes one slot per cycle.
// busy is high while a request is at work; a new request may be taken in
// the same cycle that the previous result is shown.
// After reset the block clears every slot of the slot memory, one slot per
// cycle, with busy high. entry_limit resets to 1013 and is written through
// csr_wr_en / csr_wr_data, which are taken at any time.

module open_addressed_inode_table
   import oait_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [KEY_W-1:0]   req_key_inode,
   input  logic [KEY_W-1:0]   req_parent_inode,
   output logic               rsp_valid,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [SLOT_W-1:0]  rsp_slot_index,
   output logic [KEY_W-1:0]   rsp_stored_parent,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   // Slot memory: key in the upper half, parent in the lower half.
   logic [ENTRY_W-1:0] slot_mem [TABLE_SIZE];
   logic [ENTRY_W-1:0] rdata_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [IDX_W-1:0]   mem_raddr;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [IDX_W-1:0]   probe_cnt_ff, probe_cnt_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [KEY_W-1:0]   parent_ff, parent_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [KEY_W-1:0]   rsp_parent_ff, rsp_parent_in;

   logic [KEY_W-1:0]   rd_key;
   logic [KEY_W-1:0]   rd_parent;
   logic               accept;
   logic               key_match;
   logic               slot_empty;
   logic               probe_last;
   logic               room_left;

   assign rd_key     = rdata_ff[ENTRY_W-1:KEY_W];
   assign rd_parent  = rdata_ff[KEY_W-1:0];
   assign accept     = start && (state_ff == S_IDLE);
   assign key_match  = (rd_key == key_ff);
   assign slot_empty = (rd_key == '0);
   assign probe_last = (probe_cnt_ff == LAST_IDX);
   assign room_left  = (count_ff < {1'b0, limit_ff});

   // Memory port: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= slot_mem[mem_raddr];
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= ENTRY_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      probe_cnt_ff  <= probe_cnt_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      parent_ff     <= parent_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_parent_ff <= rsp_parent_in;
   end

   // Sequencer: next state, memory controls and result words.
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      probe_cnt_in  = probe_cnt_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      parent_in     = parent_ff;
      count_in      = count_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_parent_in = rsp_parent_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = '0;
      mem_raddr     = addr_ff + 1'b1;

      case (state_ff)
         S_INIT: begin
            // Sweep zeros over every slot after reset.
            mem_we  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            // The home slot is read while waiting, so probing starts at once.
            mem_raddr = req_key_inode[IDX_W-1:0];
            if (accept) begin
               mode_in      = req_mode;
               key_in       = req_key_inode;
               parent_in    = req_parent_inode;
               addr_in      = req_key_inode[IDX_W-1:0];
               probe_cnt_in = '0;
               if (req_mode == MODE_CLEAR) begin
                  addr_in  = '0;
                  state_in = S_CLEAR;
               end else if (req_key_inode == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_MISS;
                  rsp_slot_in   = '0;
                  rsp_parent_in = '0;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end

         S_PROBE: begin
            // One slot is examined per cycle while the next one is read.
            if (key_match) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_HIT;
               rsp_slot_in   = SLOT_W'(addr_ff);
               rsp_parent_in = rd_parent;
               if (mode_ff == MODE_SET) begin
                  mem_we        = 1'b1;
                  mem_wdata     = {key_ff, parent_ff};
                  rsp_parent_in = parent_ff;
               end
               state_in = S_IDLE;
            end else if (slot_empty) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_MISS;
               rsp_slot_in   = '0;
               rsp_parent_in = '0;
               if (mode_ff == MODE_INSERT) begin
                  if (room_left) begin
                     mem_we        = 1'b1;
                     mem_wdata     = {key_ff, {KEY_W{1'b0}}};
                     count_in      = count_ff + 1'b1;
                     rsp_status_in = ST_INSERTED;
                     rsp_slot_in   = SLOT_W'(addr_ff);
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end
               state_in = S_IDLE;
            end else if (probe_last) begin
               // Every slot holds another key.
               rsp_valid_in  = 1'b1;
               rsp_status_in = (mode_ff == MODE_INSERT) ? ST_FULL : ST_MISS;
               rsp_slot_in   = '0;
               rsp_parent_in = '0;
               state_in      = S_IDLE;
            end else begin
               addr_in      = addr_ff + 1'b1;
               probe_cnt_in = probe_cnt_ff + 1'b1;
            end
         end

         S_CLEAR: begin
            // Same sweep as after reset, then report and drop the count.
            mem_we  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               count_in      = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_HIT;
               rsp_slot_in   = '0;
               rsp_parent_in = '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_stored_parent = rsp_parent_ff;

endmodule

// ===== rtl/oait_checker.sv =====
// Port-level checks for the open-addressed inode table, bound to the top.
// Depends on oait_pkg and open_addressed_inode_table.
`timescale 1ns / 1ps

module oait_checker
   import oait_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [MODE_W-1:0] req_mode,
   input logic [KEY_W-1:0]  req_key_inode,
   input logic              rsp_valid,
   input logic [STAT_W-1:0] rsp_status,
   input logic [SLOT_W-1:0] rsp_slot_index,
   input logic [KEY_W-1:0]  rsp_stored_parent
);

   // A result word is only shown once the block is free again.
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // Miss and full carry no slot and no parent.
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MISS || rsp_status == ST_FULL)
      |-> (rsp_slot_index == '0) && (rsp_stored_parent == '0))
      else $error("miss or full result with nonzero fields");

   // A fresh entry always starts with a zero parent.
   a_insert_parent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_INSERTED) |-> (rsp_stored_parent == '0))
      else $error("inserted entry with nonzero parent");

   // Key zero is refused in the very next cycle.
   a_zero_key: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode != MODE_CLEAR) && (req_key_inode == '0)
      |=> rsp_valid && (rsp_status == ST_MISS) && !busy)
      else $error("zero key not answered with an immediate miss");

   // Any other request makes the block busy in the cycle after it is taken, with no result shown then.
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      start && !busy && ((req_mode == MODE_CLEAR) || (req_key_inode != '0))
      |=> busy && !rsp_valid)
      else $error("probing or clearing request did not hold busy");

endmodule

bind open_addressed_inode_table oait_checker u_oait_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_mode          (req_mode),
   .req_key_inode     (req_key_inode),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_slot_index    (rsp_slot_index),
   .rsp_stored_parent (rsp_stored_parent)
);
